FILE: rtl/atilt_pkg.sv
// ----------------------------------------------------------------------------
// Tilt angle package
// Widths, special-case codes and the CORDIC angle table shared by the core
// and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package atilt_pkg;

    // Field widths.
    localparam int AXIS_W   = 13;
    localparam int OP_W     = 2;
    localparam int ANG_W    = 11;

    // Square root datapath: sum of two squares, scaled by 2^32.
    localparam int SQ_W     = 25;
    localparam int SUM_W    = 26;
    localparam int FRAC_SH  = 32;
    localparam int REM_W    = SUM_W + FRAC_SH;
    localparam int ROOT_W   = REM_W / 2;

    // CORDIC datapath.
    localparam int FRAC_BITS = 16;
    localparam int CW        = 34;
    localparam int ACC_W     = 32;
    localparam int TABLE_LEN = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    // Angle limit in tenths of a degree.
    localparam int ANG_MAX  = 900;

    // Register stages outside the CORDIC chain: select, square, sum,
    // one per root bit, operand forming and output.
    localparam int FIXED_STAGES = 5 + ROOT_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ANG_Z = 2'd0;
    localparam logic [OP_W-1:0] OP_ANG_X = 2'd1;
    localparam logic [OP_W-1:0] OP_ANG_Y = 2'd2;
    localparam logic [OP_W-1:0] OP_ZERO  = 2'd3;

    // Special-case result codes carried down the pipeline.
    typedef logic [1:0] t_spec;
    localparam t_spec SPEC_NONE = 2'd0;
    localparam t_spec SPEC_ZERO = 2'd1;
    localparam t_spec SPEC_POS  = 2'd2;
    localparam t_spec SPEC_NEG  = 2'd3;

    // atan(2^-i) in tenths of a degree, scaled by 2^16.
    localparam logic [ACC_W-1:0] ANGLE_TABLE [TABLE_LEN] = '{
        32'd29491225, 32'd17409687, 32'd9198800, 32'd4669455, 32'd2343788,
        32'd1173037,  32'd586661,   32'd293349,  32'd146677,  32'd73339,
        32'd36669,    32'd18335,    32'd9167,    32'd4584,    32'd2292,
        32'd1146,     32'd573,      32'd286,     32'd143,     32'd72,
        32'd36,       32'd18,       32'd9,       32'd4
    };

endpackage

`default_nettype wire

FILE: rtl/accel_tilt_angle_core.sv
// ----------------------------------------------------------------------------
// Accelerometer tilt angle core
// Pipelined square root and vectoring CORDIC giving a tilt angle in tenths
// of a degree from one three-axis acceleration sample.
// ----------------------------------------------------------------------------
// Usage:
//   A word is accepted on the rising edge where start is high and busy is
//   low. busy is always low: the pipeline takes a new word every cycle.
//   Each word gives exactly one result, shown on o_angle_tenths for one
//   cycle with o_strobe high; the receiver cannot stall it.
//   A result passes through the select, square and sum stages, the
//   bit-per-stage square root (29 stages), one stage per CORDIC
//   iteration, and the operand and output stages.
//   Throughput is one word per cycle.
//   Operation 0 gives the angle to Z, 1 the angle to X, 2 the angle to Y,
//   3 gives zero. A zero denominator gives +900 or -900 by the sign of the
//   numerator, and zero over zero gives zero.
//   A synchronous reset clears all valid bits, so no result appears for
//   words in flight at reset; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_angle_core
    import atilt_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [OP_W-1:0]          i_operation,
    input  wire logic signed [AXIS_W-1:0] i_accel_x,
    input  wire logic signed [AXIS_W-1:0] i_accel_y,
    input  wire logic signed [AXIS_W-1:0] i_accel_z,
    output logic                          o_strobe,
    output logic signed [ANG_W-1:0]       o_angle_tenths
);

    // The pipeline never stalls.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 0: choose the two axes under the root and the plain axis.
    // ------------------------------------------------------------------
    logic                     r_s0_vld;
    logic signed [AXIS_W-1:0] r_s0_p, r_s0_q, r_s0_axis;
    logic                     r_s0_root_num;
    t_spec                    r_s0_spec;

    logic signed [AXIS_W-1:0] n_s0_p, n_s0_q, n_s0_axis;
    logic                     n_s0_root_num;
    t_spec                    n_s0_spec;
    logic                     x_zero, y_zero, z_zero;

    always_comb begin
        x_zero        = (i_accel_x == '0);
        y_zero        = (i_accel_y == '0);
        z_zero        = (i_accel_z == '0);
        n_s0_p        = i_accel_x;
        n_s0_q        = i_accel_y;
        n_s0_axis     = i_accel_z;
        n_s0_root_num = 1'b1;
        n_s0_spec     = SPEC_NONE;
        unique case (i_operation)
            OP_ANG_Z: begin
                if (z_zero) begin
                    n_s0_spec = (x_zero && y_zero) ? SPEC_ZERO : SPEC_POS;
                end
            end
            OP_ANG_X: begin
                n_s0_p        = i_accel_y;
                n_s0_q        = i_accel_z;
                n_s0_axis     = i_accel_x;
                n_s0_root_num = 1'b0;
                if (y_zero && z_zero) begin
                    n_s0_spec = x_zero ? SPEC_ZERO :
                                (i_accel_x[AXIS_W-1] ? SPEC_NEG : SPEC_POS);
                end
            end
            OP_ANG_Y: begin
                n_s0_p        = i_accel_x;
                n_s0_q        = i_accel_z;
                n_s0_axis     = i_accel_y;
                n_s0_root_num = 1'b0;
                if (x_zero && z_zero) begin
                    n_s0_spec = y_zero ? SPEC_ZERO :
                                (i_accel_y[AXIS_W-1] ? SPEC_NEG : SPEC_POS);
                end
            end
            default: begin
                n_s0_spec = SPEC_ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= start && !busy;
        end
        r_s0_p        <= n_s0_p;
        r_s0_q        <= n_s0_q;
        r_s0_axis     <= n_s0_axis;
        r_s0_root_num <= n_s0_root_num;
        r_s0_spec     <= n_s0_spec;
    end

    // ------------------------------------------------------------------
    // Stage 1: the two squares.
    // ------------------------------------------------------------------
    logic                     r_s1_vld;
    logic [SQ_W-1:0]          r_s1_pp, r_s1_qq;
    logic signed [AXIS_W-1:0] r_s1_axis;
    logic                     r_s1_root_num;
    t_spec                    r_s1_spec;
    logic signed [2*AXIS_W-1:0] n_s1_pp, n_s1_qq;

    assign n_s1_pp = r_s0_p * r_s0_p;
    assign n_s1_qq = r_s0_q * r_s0_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_s0_vld;
        end
        r_s1_pp       <= n_s1_pp[SQ_W-1:0];
        r_s1_qq       <= n_s1_qq[SQ_W-1:0];
        r_s1_axis     <= r_s0_axis;
        r_s1_root_num <= r_s0_root_num;
        r_s1_spec     <= r_s0_spec;
    end

    // ------------------------------------------------------------------
    // Square root: stage 0 holds the scaled sum, then one root bit per
    // stage by the restoring method.
    // ------------------------------------------------------------------
    logic                     r_sq_vld      [ROOT_W+1];
    logic [REM_W-1:0]         r_sq_rem      [ROOT_W+1];
    logic [ROOT_W-1:0]        r_sq_root     [ROOT_W+1];
    logic signed [AXIS_W-1:0] r_sq_axis     [ROOT_W+1];
    logic                     r_sq_root_num [ROOT_W+1];
    t_spec                    r_sq_spec     [ROOT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else begin
            r_sq_vld[0] <= r_s1_vld;
        end
        r_sq_rem[0]      <= {({1'b0, r_s1_pp} + {1'b0, r_s1_qq}), {FRAC_SH{1'b0}}};
        r_sq_root[0]     <= '0;
        r_sq_axis[0]     <= r_s1_axis;
        r_sq_root_num[0] <= r_s1_root_num;
        r_sq_spec[0]     <= r_s1_spec;
    end

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int K = ROOT_W - 1 - j;
        logic [REM_W-1:0] trial;
        logic             take;

        // Growth of the square when root bit K is set.
        assign trial = ({{(REM_W-ROOT_W){1'b0}}, r_sq_root[j]} << (K + 1))
                     | ({{(REM_W-1){1'b0}}, 1'b1} << (2 * K));
        assign take  = (r_sq_rem[j] >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[j+1] <= 1'b0;
            end else begin
                r_sq_vld[j+1] <= r_sq_vld[j];
            end
            r_sq_rem[j+1]      <= take ? (r_sq_rem[j] - trial) : r_sq_rem[j];
            r_sq_root[j+1]     <= take ? (r_sq_root[j] | (ROOT_W'(1) << K))
                                       : r_sq_root[j];
            r_sq_axis[j+1]     <= r_sq_axis[j];
            r_sq_root_num[j+1] <= r_sq_root_num[j];
            r_sq_spec[j+1]     <= r_sq_spec[j];
        end
    end

    // ------------------------------------------------------------------
    // Operand stage: vector (|den|, num * sign(den)) for the CORDIC.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] axis_ext, root_ext, num, den;
    logic signed [CW-1:0] n_a0, n_b0;

    always_comb begin
        axis_ext = {{(CW-AXIS_W-FRAC_BITS){r_sq_axis[ROOT_W][AXIS_W-1]}},
                    r_sq_axis[ROOT_W], {FRAC_BITS{1'b0}}};
        root_ext = {{(CW-ROOT_W){1'b0}}, r_sq_root[ROOT_W]};
        num      = r_sq_root_num[ROOT_W] ? root_ext : axis_ext;
        den      = r_sq_root_num[ROOT_W] ? axis_ext : root_ext;
        n_a0     = den[CW-1] ? -den : den;
        n_b0     = den[CW-1] ? -num : num;
    end

    logic                     r_c_vld  [CORDIC_STEPS+1];
    logic signed [CW-1:0]     r_c_a    [CORDIC_STEPS+1];
    logic signed [CW-1:0]     r_c_b    [CORDIC_STEPS+1];
    logic signed [ACC_W-1:0]  r_c_acc  [CORDIC_STEPS+1];
    t_spec                    r_c_spec [CORDIC_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld[0] <= 1'b0;
        end else begin
            r_c_vld[0] <= r_sq_vld[ROOT_W];
        end
        r_c_a[0]    <= n_a0;
        r_c_b[0]    <= n_b0;
        r_c_acc[0]  <= '0;
        r_c_spec[0] <= r_sq_spec[ROOT_W];
    end

    // ------------------------------------------------------------------
    // Vectoring CORDIC, one iteration per stage.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [CW-1:0] da, db;
        logic                 up;

        assign da = r_c_b[i] >>> i;
        assign db = r_c_a[i] >>> i;
        assign up = !r_c_b[i][CW-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_vld[i+1] <= 1'b0;
            end else begin
                r_c_vld[i+1] <= r_c_vld[i];
            end
            r_c_a[i+1]    <= up ? (r_c_a[i] + da) : (r_c_a[i] - da);
            r_c_b[i+1]    <= up ? (r_c_b[i] - db) : (r_c_b[i] + db);
            r_c_acc[i+1]  <= up ? (r_c_acc[i] + signed'(ANGLE_TABLE[i]))
                                : (r_c_acc[i] - signed'(ANGLE_TABLE[i]));
            r_c_spec[i+1] <= r_c_spec[i];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: drop the fraction toward zero, saturate, apply the
    // special cases.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_fin, acc_adj, whole;
    logic signed [ANG_W-1:0] n_angle;

    always_comb begin
        acc_fin = r_c_acc[CORDIC_STEPS];
        acc_adj = acc_fin[ACC_W-1]
                ? (acc_fin + ACC_W'((1 << FRAC_BITS) - 1)) : acc_fin;
        whole   = acc_adj >>> FRAC_BITS;
        if (whole > ACC_W'(ANG_MAX)) begin
            n_angle = ANG_W'(ANG_MAX);
        end else if (whole < -ACC_W'(ANG_MAX)) begin
            n_angle = -ANG_W'(ANG_MAX);
        end else begin
            n_angle = whole[ANG_W-1:0];
        end
        case (r_c_spec[CORDIC_STEPS])
            SPEC_ZERO: n_angle = '0;
            SPEC_POS:  n_angle = ANG_W'(ANG_MAX);
            SPEC_NEG:  n_angle = -ANG_W'(ANG_MAX);
            default:   ;
        endcase
    end

    logic                    r_out_vld;
    logic signed [ANG_W-1:0] r_out_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_c_vld[CORDIC_STEPS];
        end
        r_out_angle <= n_angle;
    end

    assign o_strobe       = r_out_vld;
    assign o_angle_tenths = r_out_angle;

endmodule

`default_nettype wire

FILE: rtl/atilt_checker.sv
// ----------------------------------------------------------------------------
// Tilt angle port checker
// Watches the core's ports for latency, range and special-case results.
// ----------------------------------------------------------------------------
`default_nettype none

module atilt_checker
    import atilt_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic [OP_W-1:0]          i_operation,
    input wire logic signed [AXIS_W-1:0] i_accel_x,
    input wire logic signed [AXIS_W-1:0] i_accel_y,
    input wire logic signed [AXIS_W-1:0] i_accel_z,
    input wire logic                     o_strobe,
    input wire logic signed [ANG_W-1:0]  o_angle_tenths
);

    localparam int LAT = FIXED_STAGES + CORDIC_STEPS;

    // Every result word follows an accepted word by the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result word without a matching input word");

    // The angle stays within a quarter turn.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_angle_tenths <= 11'sd900 && o_angle_tenths >= -11'sd900))
        else $error("angle out of range");

    // The zero operation gives a zero angle.
    a_op_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_ZERO)
        |-> ##LAT (o_strobe && o_angle_tenths == '0))
        else $error("zero operation gave a nonzero angle");

    // The Z angle with zero Z and a nonzero X gives a full quarter turn.
    a_z_vertical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_ANG_Z && i_accel_z == '0
         && i_accel_x != '0)
        |-> ##LAT (o_strobe && o_angle_tenths == 11'sd900))
        else $error("vertical Z angle is not a quarter turn");

endmodule

bind accel_tilt_angle_core atilt_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_atilt_checker (.*);

`default_nettype wire

FILE: tb/tb_accel_tilt_angle_core.sv
// ----------------------------------------------------------------------------
// Tilt angle core testbench
// Drives acceleration words through the core, predicts every angle with a
// fixed-point square root and CORDIC of its own, and checks each result word
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_accel_tilt_angle_core;
    import atilt_pkg::*;

    localparam int STEPS     = CORDIC_STEPS_DEF;
    localparam int LATENCY   = 34 + STEPS;
    localparam int WATCHDOG  = 20000;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } t_sample;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [OP_W-1:0]               i_operation;
    logic signed [AXIS_W-1:0]      i_accel_x;
    logic signed [AXIS_W-1:0]      i_accel_y;
    logic signed [AXIS_W-1:0]      i_accel_z;
    logic                          o_strobe;
    logic signed [ANG_W-1:0]       o_angle_tenths;

    t_sample                  pending_samples[$];
    logic signed [ANG_W-1:0]  expected_angles[$];
    int                       idle_pct;
    bit                       hold_sender;
    int                       errors;
    int                       words_in;
    int                       words_out;
    int                       quiet_cycles;

    accel_tilt_angle_core #(.CORDIC_STEPS(STEPS)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .o_strobe       (o_strobe),
        .o_angle_tenths (o_angle_tenths)
    );

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Exact floor square root of a 64-bit value.
    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Root of a sum of two squares, with 16 fraction bits.
    function automatic longint hypot_fixed(longint p, longint q);
        longint unsigned s;
        s = longint'(p * p + q * q);
        return longint'(isqrt64(s << 32));
    endfunction

    // Predicted angle in tenths of a degree for one sample.
    function automatic logic signed [ANG_W-1:0] tilt_tenths(t_sample s);
        longint num;
        longint den;
        longint a;
        longint b;
        longint da;
        longint db;
        longint acc;
        longint t;
        case (s.op)
            OP_ANG_Z: begin
                num = hypot_fixed(s.x, s.y);
                den = longint'(s.z) * 65536;
            end
            OP_ANG_X: begin
                num = longint'(s.x) * 65536;
                den = hypot_fixed(s.y, s.z);
            end
            OP_ANG_Y: begin
                num = longint'(s.y) * 65536;
                den = hypot_fixed(s.x, s.z);
            end
            default: return '0;
        endcase
        if (den == 0) begin
            if (num == 0) return '0;
            return (num > 0) ? ANG_W'(ANG_MAX) : ANG_W'(-ANG_MAX);
        end
        a = (den < 0) ? -den : den;
        b = (den < 0) ? -num : num;
        acc = 0;
        for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0) begin
                a += da;
                b -= db;
                acc += longint'(ANGLE_TABLE[i]);
            end else begin
                a -= da;
                b += db;
                acc -= longint'(ANGLE_TABLE[i]);
            end
        end
        t = acc / 65536;
        if (t > ANG_MAX) t = ANG_MAX;
        if (t < -ANG_MAX) t = -ANG_MAX;
        return ANG_W'(t);
    endfunction

    // Random axis value, biased toward extremes and small values.
    function automatic logic signed [AXIS_W-1:0] rand_axis();
        case ($urandom_range(9))
            0: return AXIS_W'(-4096);
            1: return AXIS_W'(4095);
            2: return '0;
            3: return AXIS_W'($urandom_range(6)) - AXIS_W'(3);
            default: return AXIS_W'($urandom);
        endcase
    endfunction

    // Driver: presents one word per cycle from the pending queue, unless hold_sender is set or an idle cycle is drawn.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_sender || pending_samples.size() == 0
                || $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
        end else begin
            start       <= 1'b1;
            i_operation <= pending_samples[0].op;
            i_accel_x   <= pending_samples[0].x;
            i_accel_y   <= pending_samples[0].y;
            i_accel_z   <= pending_samples[0].z;
            void'(pending_samples.pop_front());
        end
    end

    // Monitor: predicts accepted words and checks result words.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles <= ((start && !busy) || o_strobe) ? 0 : quiet_cycles + 1;
            if (start && !busy) begin
                expected_angles.push_back(tilt_tenths(
                    '{op: i_operation, x: i_accel_x, y: i_accel_y, z: i_accel_z}));
                words_in <= words_in + 1;
            end
            if (o_strobe) begin
                words_out <= words_out + 1;
                if (expected_angles.size() == 0) begin
                    $error("angle_tenths: unexpected result %0d", o_angle_tenths);
                    errors++;
                end else begin
                    if (o_angle_tenths !== expected_angles[0]) begin
                        $error("angle_tenths: expected %0d, actual %0d",
                               expected_angles[0], o_angle_tenths);
                        errors++;
                    end
                    void'(expected_angles.pop_front());
                end
            end
        end
    end

    // Watchdog on cycles with no accepted word and no result word.
    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG) begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        t_sample s;
        logic [OP_W-1:0] ops[4];
        start = 1'b0;
        i_operation = '0;
        i_accel_x = '0;
        i_accel_y = '0;
        i_accel_z = '0;
        i_rst_n = 1'b0;
        idle_pct = 0;
        hold_sender = 1'b0;
        errors = 0;
        words_in = 0;
        words_out = 0;
        quiet_cycles = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words: every operation with extremes and zero cases.
        ops = '{OP_ANG_Z, OP_ANG_X, OP_ANG_Y, OP_ZERO};
        foreach (ops[k]) begin
            pending_samples.push_back('{ops[k], AXIS_W'(-4096), AXIS_W'(-4096),
                                      AXIS_W'(-4096)});
            pending_samples.push_back('{ops[k], AXIS_W'(4095), AXIS_W'(4095),
                                      AXIS_W'(4095)});
            pending_samples.push_back('{ops[k], '0, '0, '0});
        end
        // Zero denominators with a numerator of either sign.
        pending_samples.push_back('{OP_ANG_Z, AXIS_W'(5), '0, '0});
        pending_samples.push_back('{OP_ANG_X, AXIS_W'(-7), '0, '0});
        pending_samples.push_back('{OP_ANG_X, AXIS_W'(4095), '0, '0});
        pending_samples.push_back('{OP_ANG_Y, '0, AXIS_W'(-4096), '0});
        pending_samples.push_back('{OP_ANG_Y, '0, AXIS_W'(1), '0});
        // Negative denominator for the Z angle, and a negative X numerator.
        pending_samples.push_back('{OP_ANG_Z, AXIS_W'(100), AXIS_W'(-3),
                                  AXIS_W'(-1)});
        pending_samples.push_back('{OP_ANG_Z, '0, '0, AXIS_W'(-4096)});
        pending_samples.push_back('{OP_ANG_X, AXIS_W'(-4096), AXIS_W'(4095),
                                  AXIS_W'(-4096)});

        // Pause the sender until every directed result has arrived.
        wait (pending_samples.size() == 0);
        hold_sender = 1'b1;
        repeat (2) @(posedge i_clk);
        wait (expected_angles.size() == 0 && words_in > 0);
        hold_sender = 1'b0;

        // Random words in four idling phases.
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 0) ? 0 : (phase == 3) ? 29 : 66;
            for (int n = 0; n < 225; n++) begin
                s.op = OP_W'($urandom);
                s.x = rand_axis();
                s.y = rand_axis();
                s.z = rand_axis();
                pending_samples.push_back(s);
            end
            wait (pending_samples.size() == 0);
        end

        // The last word is taken at the next rising edge.
        repeat (2) @(posedge i_clk);
        wait (expected_angles.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d angle words from %0d samples over all operations,",
                 words_out, words_in);
        $display("axis extremes, zero denominators and four idling phases.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
